// ===== src/lus_pkg.sv =====
// ----------------------------------------------------------------------------
// lus_pkg
// Shared types and constants for the largest unused subrange finder.
// ----------------------------------------------------------------------------
`default_nettype none

package lus_pkg;

  localparam int unsigned MAX_RANGES = 256;
  localparam int unsigned IDX_W      = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned VAL_W      = 17;

  // whole 16-bit code space
  localparam logic [VAL_W-1:0] RANGE_LENGTH_RESET = VAL_W'(1 << CODE_W);

  localparam logic CFG_RANGE_START  = 1'b0;
  localparam logic CFG_RANGE_LENGTH = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] len;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // outcome of checking one table entry against the current code
  typedef struct packed {
    logic   hit;      // entry contains the code
    logic   split;    // code is strictly inside, upper part needs a new entry
    logic   greater;  // entry length beats the best length so far
    entry_t upd;      // entry after taking the code out
    entry_t upper;    // upper part of a split
  } eval_t;

endpackage

`default_nettype wire

// ===== src/largest_unused_subrange_core.sv =====
// ----------------------------------------------------------------------------
// largest_unused_subrange_core
// Finds the first longest subrange of a configured code range that a stream
// of characters leaves unused, by splitting a table of free subranges.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, char_code,           | into block
//           | char_valid, last_char                    |
//   out     | out_valid, out_stall, best_start,        | out of block
//           | best_length, table_overflow              |
//   cfg     | cfg_we, cfg_index, cfg_data              | into block
//
// A word with no table work needs no sweep. A word with a character in
// range sweeps the table RAM one entry a cycle through its single read port
// and keeps in_stall high until the sweep and any append are done; the
// table holds at most 256 entries. A last word sweeps again for the best
// entry; its result loads the output register once any earlier result held
// there has been taken.
// After reset or a config write the block reloads entry 0 before going idle;
// after a result entry 0 is reloaded as the output register loads.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_unused_subrange_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [lus_pkg::VAL_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [lus_pkg::CODE_W-1:0]    char_code,
  input  wire logic                          char_valid,
  input  wire logic                          last_char,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [lus_pkg::VAL_W-1:0]     best_start,
  output      logic [lus_pkg::VAL_W-1:0]     best_length,
  output      logic                          table_overflow
);

  typedef enum logic [2:0] {
    S_RELOAD,
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_OUT
  } state_t;

  state_t                      state;
  logic [lus_pkg::CODE_W-1:0]  range_start;
  logic [lus_pkg::VAL_W-1:0]   range_length;
  logic [lus_pkg::CNT_W-1:0]   entry_count;
  logic                        overflow_seen;
  logic                        find_best;
  logic                        last_q;
  logic [lus_pkg::CODE_W-1:0]  code_q;
  logic [lus_pkg::CNT_W-1:0]   ptr;
  logic                        pend;
  logic [lus_pkg::IDX_W-1:0]   pend_idx;
  lus_pkg::entry_t             append_q;
  logic [lus_pkg::VAL_W-1:0]   lead_base;
  logic [lus_pkg::VAL_W-1:0]   lead_len;

  logic                        in_accept;
  logic                        out_accept;
  logic                        load_out;
  logic                        issue;
  lus_pkg::entry_t             rd_data;
  lus_pkg::entry_t             cfg_entry;
  lus_pkg::entry_t             ev_entry;
  logic [lus_pkg::CODE_W-1:0]  ev_code;
  lus_pkg::eval_t              ev;
  logic                        char_hit;
  logic                        wr_en;
  logic [lus_pkg::IDX_W-1:0]   wr_addr;
  lus_pkg::entry_t             wr_data;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // a finished string moves into the output register once it is free
  assign load_out = (state == S_OUT) && !cfg_we && (!out_valid || !out_stall);

  assign issue = (state == S_SCAN) && (ptr < entry_count);

  assign cfg_entry.base = {1'b0, range_start};
  assign cfg_entry.len  = range_length;

  // the range check on a new word goes through the same unit as the sweep
  assign ev_entry = (state == S_IDLE) ? cfg_entry : rd_data;
  assign ev_code  = (state == S_IDLE) ? char_code : code_q;

  lus_eval u_eval (
    .code     (ev_code),
    .ent      (ev_entry),
    .best_len (lead_len),
    .res      (ev)
  );

  assign char_hit = (state == S_SCAN) && pend && !find_best && ev.hit;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cfg_entry;
    if (state == S_RELOAD || load_out) begin
      wr_en = 1'b1;
    end else if (char_hit) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx;
      wr_data = ev.upd;
    end else if (state == S_APPEND) begin
      wr_en   = 1'b1;
      wr_addr = entry_count[lus_pkg::IDX_W-1:0];
      wr_data = append_q;
    end
  end

  lus_ram #(
    .WIDTH (lus_pkg::ENTRY_W),
    .DEPTH (lus_pkg::MAX_RANGES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (ptr[lus_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RELOAD;
      range_start   <= '0;
      range_length  <= lus_pkg::RANGE_LENGTH_RESET;
      entry_count   <= lus_pkg::CNT_W'(1);
      overflow_seen <= 1'b0;
      find_best     <= 1'b0;
      last_q        <= 1'b0;
      ptr           <= '0;
      pend          <= 1'b0;
      pend_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid      <= 1'b1;
        best_start     <= lead_base;
        best_length    <= lead_len;
        table_overflow <= overflow_seen;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          lus_pkg::CFG_RANGE_START:  range_start  <= cfg_data[lus_pkg::CODE_W-1:0];
          lus_pkg::CFG_RANGE_LENGTH: range_length <= cfg_data;
          default: range_start <= range_start;
        endcase
        state <= S_RELOAD;
      end else begin
        case (state)
          S_RELOAD: begin
            entry_count   <= lus_pkg::CNT_W'(1);
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end

          S_IDLE: begin
            if (in_accept) begin
              code_q <= char_code;
              last_q <= last_char;
              ptr    <= '0;
              pend   <= 1'b0;
              if (char_valid && ev.hit) begin
                find_best <= 1'b0;
                state     <= S_SCAN;
              end else if (last_char) begin
                find_best <= 1'b1;
                state     <= S_SCAN;
              end
            end
          end

          S_SCAN: begin
            // one read issued per cycle, data evaluated in the next cycle
            pend     <= issue;
            pend_idx <= ptr[lus_pkg::IDX_W-1:0];
            ptr      <= ptr + lus_pkg::CNT_W'(issue);
            if (pend && find_best) begin
              if (pend_idx == '0 || ev.greater) begin
                lead_base <= rd_data.base;
                lead_len  <= rd_data.len;
              end
            end
            if (char_hit) begin
              ptr  <= '0;
              pend <= 1'b0;
              if (ev.split && entry_count < lus_pkg::CNT_W'(lus_pkg::MAX_RANGES)) begin
                append_q <= ev.upper;
                state    <= S_APPEND;
              end else begin
                if (ev.split) begin
                  overflow_seen <= 1'b1;
                end
                find_best <= 1'b1;
                state     <= last_q ? S_SCAN : S_IDLE;
              end
            end else if (!issue && !pend) begin
              // sweep finished
              ptr <= '0;
              if (find_best) begin
                state <= S_OUT;
              end else begin
                find_best <= 1'b1;
                state     <= last_q ? S_SCAN : S_IDLE;
              end
            end
          end

          S_APPEND: begin
            entry_count <= entry_count + lus_pkg::CNT_W'(1);
            find_best   <= 1'b1;
            ptr         <= '0;
            pend        <= 1'b0;
            state       <= last_q ? S_SCAN : S_IDLE;
          end

          S_OUT: begin
            // entry 0 is rewritten in the same cycle the output register loads
            if (load_out) begin
              entry_count   <= lus_pkg::CNT_W'(1);
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end
          end

          default: state <= S_RELOAD;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/lus_ram.sv =====
// ----------------------------------------------------------------------------
// lus_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lus_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/lus_eval.sv =====
// ----------------------------------------------------------------------------
// lus_eval
// Shared compare unit: containment test, split of one entry around a code,
// and length compare against the best entry so far.
// ----------------------------------------------------------------------------
`default_nettype none

module lus_eval (
  input  wire logic [lus_pkg::CODE_W-1:0] code,
  input  wire lus_pkg::entry_t            ent,
  input  wire logic [lus_pkg::VAL_W-1:0]  best_len,
  output      lus_pkg::eval_t             res
);

  logic [lus_pkg::VAL_W-1:0] c;
  logic [lus_pkg::VAL_W-1:0] offs;
  logic [lus_pkg::VAL_W-1:0] len_m1;
  logic [lus_pkg::VAL_W:0]   end_sum;
  logic                      at_begin;
  logic                      at_end;

  always_comb begin
    c        = {1'b0, code};
    offs     = c - ent.base;
    len_m1   = ent.len - lus_pkg::VAL_W'(1);
    // base + len - code - 1, kept to the value width
    end_sum  = {1'b0, ent.base} + {1'b0, ent.len} - {1'b0, c} - (lus_pkg::VAL_W + 1)'(1);
    at_begin = (c == ent.base);
    at_end   = (offs == len_m1);

    res.hit     = (c >= ent.base) && (offs < ent.len);
    res.split   = !at_begin && !at_end;
    res.greater = (ent.len > best_len);

    res.upd.base = ent.base;
    res.upd.len  = offs;
    if (at_begin) begin
      res.upd.base = ent.base + lus_pkg::VAL_W'(1);
      res.upd.len  = len_m1;
    end else if (at_end) begin
      res.upd.len  = len_m1;
    end

    res.upper.base = c + lus_pkg::VAL_W'(1);
    res.upper.len  = end_sum[lus_pkg::VAL_W-1:0];
  end

endmodule

`default_nettype wire

// ===== tb/lus_free_run_check.sv =====
// ----------------------------------------------------------------------------
// lus_free_run_check
// Watches the config, input and result channels of the largest unused
// subrange finder. It keeps its own table of free subranges, predicts the
// first longest free run for every word marked last and compares each
// delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
module lus_free_run_check
  import lus_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [VAL_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [CODE_W-1:0]  char_code,
  input  wire logic               char_valid,
  input  wire logic               last_char,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [VAL_W-1:0]   best_start,
  input  wire logic [VAL_W-1:0]   best_length,
  input  wire logic               table_overflow,
  output int unsigned             fail_count,
  output int unsigned             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] run_start;
    logic [VAL_W-1:0] run_len;
    logic             dropped;
  } free_run_t;

  logic [CODE_W-1:0] cur_start;
  logic [VAL_W-1:0]  cur_length;
  logic [VAL_W-1:0]  free_begin [MAX_RANGES];
  logic [VAL_W-1:0]  free_size  [MAX_RANGES];
  int unsigned       free_count;
  logic              split_dropped;
  free_run_t         longest_q [$];
  int unsigned       mismatches = 0;

  function automatic void reload_free_table();
    free_begin[0] = {1'b0, cur_start};
    free_size[0]  = cur_length;
    free_count    = 1;
    split_dropped = 1'b0;
  endfunction

  // take one code out of the first free run that holds it
  function automatic void claim_code(input logic [CODE_W-1:0] code);
    int unsigned cv;
    int unsigned lo;
    int unsigned sz;
    logic        found;
    cv    = code;
    found = 1'b0;
    if (cv >= cur_start && cv - cur_start < cur_length) begin
      for (int unsigned k = 0; k < free_count && !found; k++) begin
        lo = free_begin[k];
        sz = free_size[k];
        if (cv >= lo && cv - lo < sz) begin
          found = 1'b1;
          if (cv == lo) begin
            free_begin[k] = VAL_W'(lo + 1);
            free_size[k]  = VAL_W'(sz - 1);
          end else if (cv - lo == sz - 1) begin
            free_size[k] = VAL_W'(sz - 1);
          end else begin
            if (free_count < MAX_RANGES) begin
              free_begin[free_count] = VAL_W'(cv + 1);
              free_size[free_count]  = VAL_W'(lo + sz - cv - 1);
              free_count++;
            end else begin
              split_dropped = 1'b1;
            end
            free_size[k] = VAL_W'(cv - lo);
          end
        end
      end
    end
  endfunction

  // earliest entry wins a tie
  function automatic free_run_t longest_free_run();
    free_run_t   run;
    int unsigned top;
    top = 0;
    for (int unsigned k = 1; k < free_count; k++) begin
      if (free_size[k] > free_size[top]) top = k;
    end
    run.run_start = free_begin[top];
    run.run_len   = free_size[top];
    run.dropped   = split_dropped;
    return run;
  endfunction

  always @(posedge clk) begin : watch
    free_run_t want;
    if (rst) begin
      cur_start  = '0;
      cur_length = 17'h10000;
      reload_free_table();
      longest_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RANGE_START) cur_start = cfg_data[CODE_W-1:0];
        else cur_length = cfg_data;
        reload_free_table();
      end
      if (in_valid && !in_stall) begin
        if (char_valid) claim_code(char_code);
        if (last_char) begin
          longest_q.push_back(longest_free_run());
          reload_free_table();
        end
      end
      if (out_valid && !out_stall) begin
        if (longest_q.size() == 0) begin
          mismatches++;
          $error("result with nothing expected: best_start %0d best_length %0d overflow %0d",
                 best_start, best_length, table_overflow);
        end else begin
          want = longest_q.pop_front();
          if (best_start !== want.run_start) begin
            mismatches++;
            $error("best_start mismatch: expected %0d, actual %0d", want.run_start, best_start);
          end
          if (best_length !== want.run_len) begin
            mismatches++;
            $error("best_length mismatch: expected %0d, actual %0d", want.run_len, best_length);
          end
          if (table_overflow !== want.dropped) begin
            mismatches++;
            $error("table_overflow mismatch: expected %0d, actual %0d",
                   want.dropped, table_overflow);
          end
        end
      end
    end
    pending    <= longest_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_largest_unused_subrange_core.sv =====
// ----------------------------------------------------------------------------
// tb_largest_unused_subrange_core
// Drives strings of characters into the largest unused subrange finder under
// a series of range settings, with random gaps on the input and random
// stalls on the result side, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_largest_unused_subrange_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lus_pkg::*;

  localparam int unsigned WORD_TARGET       = 1650;
  localparam int unsigned DRAIN_CYCLES      = 2 * MAX_RANGES + 8;
  localparam int unsigned CYCLE_LIMIT       = 4_000_000;
  localparam int unsigned END_WAIT_LIMIT    = 100_000;
  localparam int unsigned LONG_HOLD         = 3000;
  localparam int unsigned STRINGS_PER_PHASE = 6;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = CFG_RANGE_START;
  logic [VAL_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [CODE_W-1:0] char_code  = '0;
  logic              char_valid = 1'b0;
  logic              last_char  = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [VAL_W-1:0]  best_start;
  logic [VAL_W-1:0]  best_length;
  logic              table_overflow;

  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       range_lo      = 0;
  int unsigned       range_len     = 65536;
  int unsigned       words_sent    = 0;
  int unsigned       cycle_count   = 0;
  logic              steady_sender = 1'b0;
  logic              hold_off_req  = 1'b0;
  logic              hold_done     = 1'b0;
  logic [CODE_W-1:0] string_codes [$];

  always #2 clk = ~clk;

  largest_unused_subrange_core u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .char_valid     (char_valid),
    .last_char      (last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .best_start     (best_start),
    .best_length    (best_length),
    .table_overflow (table_overflow)
  );

  lus_free_run_check u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .char_valid     (char_valid),
    .last_char      (last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .best_start     (best_start),
    .best_length    (best_length),
    .table_overflow (table_overflow),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned r;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end else if (r < 80) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 95) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [VAL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_RANGE_START) range_lo = value[CODE_W-1:0];
    else range_len = value;
  endtask

  task automatic send_word(input logic [CODE_W-1:0] code, input logic valid,
                           input logic last);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 55) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 60);
    if (gap != 0) begin
      in_valid   <= 1'b0;
      char_code  <= CODE_W'($urandom);
      char_valid <= 1'($urandom);
      last_char  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    char_code  <= code;
    char_valid <= valid;
    last_char  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (valid || last) words_sent++;
  endtask

  // mostly codes inside the range, some repeats of this string, some noise
  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned       r;
    int unsigned       span;
    logic [CODE_W-1:0] code;
    span = (range_len > 65536 - range_lo) ? 65536 - range_lo : range_len;
    r    = $urandom_range(0, 99);
    if (r >= 80 && r < 90 && string_codes.size() != 0)
      code = string_codes[$urandom_range(0, string_codes.size() - 1)];
    else if (r >= 90 || span == 0)
      code = CODE_W'($urandom);
    else
      code = CODE_W'(range_lo + $urandom_range(0, span - 1));
    return code;
  endfunction

  task automatic send_string(input int unsigned len);
    logic [CODE_W-1:0] code;
    string_codes.delete();
    steady_sender = ($urandom_range(0, 99) < 25);
    for (int unsigned i = 0; i + 1 < len; i++) begin
      if ($urandom_range(0, 99) < 5) begin
        send_word(CODE_W'($urandom), 1'b0, 1'b0);
      end else begin
        code = pick_code();
        string_codes.push_back(code);
        send_word(code, 1'b1, 1'b0);
      end
    end
    if ($urandom_range(0, 99) < 15) send_word(CODE_W'($urandom), 1'b0, 1'b1);
    else send_word(pick_code(), 1'b1, 1'b1);
  endtask

  // registers only change once the block has gone quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned       strings_done;
    int unsigned       phase;
    int unsigned       len;
    int unsigned       r;
    int unsigned       pick;
    int unsigned       which;
    int unsigned       waited;
    logic [CODE_W-1:0] new_lo;
    logic [VAL_W-1:0]  new_len;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty end marker on the untouched full range
    send_word(16'h0000, 1'b0, 1'b1);
    // both ends, a split, a repeat, an ignored word, then last with a code
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h4000, 1'b1, 1'b1);

    // one-code range at the top, start runs past 16 bits once used
    wait_idle();
    write_reg(CFG_RANGE_START, 17'h0FFFF);
    write_reg(CFG_RANGE_LENGTH, 17'h00001);
    send_word(16'hFFFE, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b1);

    // empty range
    wait_idle();
    write_reg(CFG_RANGE_LENGTH, 17'h00000);
    send_word(16'hFFFF, 1'b1, 1'b1);

    // oversized length, split gives two equal runs
    wait_idle();
    write_reg(CFG_RANGE_START, 17'h00000);
    write_reg(CFG_RANGE_LENGTH, 17'h1FFFF);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b1);

    // tiny range used up from the middle outwards
    wait_idle();
    write_reg(CFG_RANGE_START, 17'd100);
    write_reg(CFG_RANGE_LENGTH, 17'd3);
    send_word(16'd101, 1'b1, 1'b0);
    send_word(16'd100, 1'b1, 1'b0);
    send_word(16'd102, 1'b1, 1'b1);

    hold_off_req = 1'b1;
    strings_done = 0;
    phase        = 0;
    while (words_sent < WORD_TARGET) begin
      if (strings_done % STRINGS_PER_PHASE == 0) begin
        wait_idle();
        pick    = (phase == 0) ? 0 : $urandom_range(0, 6);
        new_lo  = CODE_W'(range_lo);
        new_len = VAL_W'(range_len);
        case (pick)
          0: begin
            new_lo  = 16'h0000;
            new_len = 17'h10000;
          end
          1: begin
            new_lo  = CODE_W'($urandom_range(0, 65535));
            new_len = VAL_W'($urandom_range(1, 64));
          end
          2: begin
            new_lo  = 16'hFFFF;
            new_len = VAL_W'($urandom_range(0, 1));
          end
          3: begin
            new_lo  = CODE_W'($urandom_range(0, 65535));
            new_len = VAL_W'($urandom_range(0, 65536));
          end
          4: begin
            new_lo  = CODE_W'($urandom_range(0, 65535));
            new_len = VAL_W'($urandom_range(65537, 131071));
          end
          5: begin
            new_lo  = CODE_W'($urandom_range(65000, 65535));
            new_len = 17'h10000;
          end
          default: begin
            new_lo  = 16'h0000;
            new_len = VAL_W'($urandom_range(1, 3));
          end
        endcase
        which = $urandom_range(0, 2);
        if (phase == 0 || which != 1) write_reg(CFG_RANGE_START, {1'b0, new_lo});
        if (phase == 0 || which != 0) write_reg(CFG_RANGE_LENGTH, new_len);
        phase++;
      end
      // a long string over the full range fills the table and drops splits
      r = $urandom_range(0, 99);
      if (phase == 1 && strings_done == 3) len = 360;
      else if (r < 85) len = $urandom_range(1, 20);
      else if (r < 97 || phase == 1) len = $urandom_range(21, 80);
      else len = $urandom_range(250, 340);
      send_string(len);
      strings_done++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
